### sv/lifet_pkg.sv
// Shared types and constants for the toroidal life automaton step core.
// No dependencies; used by lifet_ctrl, lifet_datapath and the top level.
`timescale 1ns / 1ps

package lifet_pkg;

    localparam int FIELD_ROW_W  = 64;
    localparam int FIELD_IDX_W  = 6;

    // Item mode codes
    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_STEP = 1'b1;

    // B3/S23 neighbor counts
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic                   mode;
        logic [FIELD_IDX_W-1:0] row_index;
        logic [FIELD_ROW_W-1:0] row_bits;
    } cmd_item_t;

    typedef struct packed {
        logic [FIELD_IDX_W-1:0] out_row_index;
        logic [FIELD_ROW_W-1:0] out_row_bits;
        logic                   last_row;
    } res_item_t;

    // Controller commands to the datapath
    typedef struct packed {
        logic load_wr;      // write the accepted load item's row
        logic rd_en;        // launch a grid read
        logic cap_above;    // capture read data as the row above
        logic cap_mid;      // capture read data as the middle row and old row 0
        logic cap_below;    // capture read data as the row below
        logic step_row;     // compute, emit and write back one row, then shift
        logic below_first;  // shift old row 0 into the below slot
        logic last;         // the row being emitted is the final one
    } ctl_cmd_t;

endpackage

### sv/lifet_ctrl.sv
// Sequencer for the life step core: handshake on the item side and row walk.
// Depends on lifet_pkg.
`timescale 1ns / 1ps

module lifet_ctrl #(
    parameter int GRID_HEIGHT = 64,
    parameter int ROW_W       = 6
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cmd_valid,
    input  logic                mode,
    output logic                cmd_ready,
    input  logic                out_free,
    output lifet_pkg::ctl_cmd_t ctl,
    output logic [ROW_W-1:0]    rd_addr,
    output logic [ROW_W-1:0]    row_sel
);

    typedef enum logic [4:0] {
        S_IDLE    = 5'b00001,
        S_PRIME_A = 5'b00010,
        S_PRIME_M = 5'b00100,
        S_PRIME_B = 5'b01000,
        S_RUN     = 5'b10000
    } state_t;

    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GRID_HEIGHT - 1);
    localparam logic [ROW_W+1:0] H_EXT    = (ROW_W + 2)'(GRID_HEIGHT);

    state_t             state_reg, state_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [ROW_W+1:0]   ahead2, ahead3;

    assign ahead2  = {2'b00, row_reg} + (ROW_W + 2)'(2);
    assign ahead3  = {2'b00, row_reg} + (ROW_W + 2)'(3);
    assign row_sel = row_reg;

    always_comb
    begin
        state_next = state_reg;
        row_next   = row_reg;
        ctl        = '0;
        rd_addr    = LAST_ROW;
        cmd_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                cmd_ready = 1'b1;
                if (cmd_valid)
                begin
                    if (mode == lifet_pkg::MODE_STEP)
                    begin
                        ctl.rd_en  = 1'b1;
                        rd_addr    = LAST_ROW;
                        state_next = S_PRIME_A;
                    end
                    else
                    begin
                        ctl.load_wr = 1'b1;
                    end
                end
            end
            S_PRIME_A:
            begin
                ctl.cap_above = 1'b1;
                ctl.rd_en     = 1'b1;
                rd_addr       = '0;
                state_next    = S_PRIME_M;
            end
            S_PRIME_M:
            begin
                ctl.cap_mid = 1'b1;
                ctl.rd_en   = 1'b1;
                rd_addr     = ROW_W'(1);
                state_next  = S_PRIME_B;
            end
            S_PRIME_B:
            begin
                ctl.cap_below = 1'b1;
                ctl.rd_en     = 1'b1;
                rd_addr       = ROW_W'(2);
                row_next      = '0;
                state_next    = S_RUN;
            end
            S_RUN:
            begin
                if (out_free)
                begin
                    ctl.step_row    = 1'b1;
                    ctl.below_first = (ahead2 == H_EXT);
                    ctl.rd_en       = (ahead3 < H_EXT);
                    rd_addr         = ahead3[ROW_W-1:0];
                    ctl.last        = (row_reg == LAST_ROW);
                    if (row_reg == LAST_ROW)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        row_next = row_reg + ROW_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            row_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
        end
    end

endmodule

### sv/lifet_datapath.sv
// Datapath for the life step core: grid memory, three-row window and
// B3/S23 row update, result register. Depends on lifet_pkg.
`timescale 1ns / 1ps

module lifet_datapath #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int ROW_W       = 6
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lifet_pkg::ctl_cmd_t  ctl,
    input  logic [ROW_W-1:0]     rd_addr,
    input  logic [ROW_W-1:0]     row_sel,
    input  lifet_pkg::cmd_item_t cmd,
    output logic                 out_free,
    output lifet_pkg::res_item_t res,
    output logic                 res_valid,
    input  logic                 res_ready
);

    logic [GRID_WIDTH-1:0]  mem [GRID_HEIGHT];
    logic [GRID_HEIGHT-1:0] vld_reg;
    logic [GRID_WIDTH-1:0]  rd_data_reg;
    logic [GRID_WIDTH-1:0]  above_reg, mid_reg, below_reg, first_reg;
    logic [GRID_WIDTH-1:0]  fresh;
    logic                   res_valid_reg;
    lifet_pkg::res_item_t   res_reg;

    logic                   ld_ok;
    logic                   wr_en;
    logic [ROW_W-1:0]       wr_addr;
    logic [GRID_WIDTH-1:0]  wr_data;

    // Drop loads aimed past the last row
    assign ld_ok   = ({1'b0, cmd.row_index} < (lifet_pkg::FIELD_IDX_W + 1)'(GRID_HEIGHT));
    assign wr_en   = ctl.step_row || (ctl.load_wr && ld_ok);
    assign wr_addr = ctl.step_row ? row_sel : cmd.row_index[ROW_W-1:0];
    assign wr_data = ctl.step_row ? fresh : cmd.row_bits[GRID_WIDTH-1:0];

    // B3/S23 on every column, wrapping at the left and right edges
    always_comb
    begin
        int         lf;
        int         rt;
        logic [3:0] cnt;
        fresh = '0;
        for (int j = 0; j < GRID_WIDTH; j++)
        begin
            lf  = (j == 0) ? GRID_WIDTH - 1 : j - 1;
            rt  = (j == GRID_WIDTH - 1) ? 0 : j + 1;
            cnt = 4'(above_reg[lf]) + 4'(above_reg[j]) + 4'(above_reg[rt])
                + 4'(mid_reg[lf]) + 4'(mid_reg[rt])
                + 4'(below_reg[lf]) + 4'(below_reg[j]) + 4'(below_reg[rt]);
            fresh[j] = (cnt == lifet_pkg::BIRTH_COUNT)
                    || (mid_reg[j] && (cnt == lifet_pkg::SURVIVE_COUNT));
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Rows never written read as dead
    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rd_data_reg <= vld_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (wr_en)
        begin
            vld_reg[wr_addr] <= 1'b1;
        end
    end

    // Row window: above / middle / below, plus old row 0 for the bottom wrap
    always_ff @(posedge clk)
    begin
        if (ctl.cap_above)
        begin
            above_reg <= rd_data_reg;
        end
        if (ctl.cap_mid)
        begin
            mid_reg   <= rd_data_reg;
            first_reg <= rd_data_reg;
        end
        if (ctl.cap_below)
        begin
            below_reg <= rd_data_reg;
        end
        if (ctl.step_row)
        begin
            above_reg <= mid_reg;
            mid_reg   <= below_reg;
            below_reg <= ctl.below_first ? first_reg : rd_data_reg;
        end
    end

    assign out_free = !res_valid_reg || res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (ctl.step_row)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.step_row)
        begin
            res_reg.out_row_index <= lifet_pkg::FIELD_IDX_W'(row_sel);
            res_reg.out_row_bits  <= lifet_pkg::FIELD_ROW_W'(fresh);
            res_reg.last_row      <= ctl.last;
        end
    end

    assign res       = res_reg;
    assign res_valid = res_valid_reg;

endmodule

### sv/life_automaton_toroidal_step_core.sv
// Flow: after acceptance a step item primes the window through S_PRIME_A,
// S_PRIME_M and S_PRIME_B before its first row; a load item is written as it
// is accepted. A step emits one row per cycle from a grid memory with one read
// and one write port while the sink keeps up, and takes no new item until done.
// Reset: clears the per-row valid flags so the whole grid reads as dead,
// empties the result register and returns the sequencer to idle.
`timescale 1ns / 1ps

module life_automaton_toroidal_step_core #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cmd_valid,
    output logic                 cmd_ready,
    input  lifet_pkg::cmd_item_t cmd,
    output logic                 res_valid,
    input  logic                 res_ready,
    output lifet_pkg::res_item_t res
);

    // Row address width follows the grid height
    localparam int ROW_W = $clog2(GRID_HEIGHT);

    // Command bundle from sequencer to datapath
    lifet_pkg::ctl_cmd_t ctl;
    logic [ROW_W-1:0]    rd_addr;
    logic [ROW_W-1:0]    row_sel;
    logic                out_free;

    // Sequencer: takes one item at a time. A load finishes in the accept
    // cycle; a step primes the window with the last row, row 0 and row 1,
    // then walks rows 0 .. GRID_HEIGHT-1, holding whenever the result
    // register cannot take a new row.
    lifet_ctrl #(
        .GRID_HEIGHT (GRID_HEIGHT),
        .ROW_W       (ROW_W)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .mode      (cmd.mode),
        .cmd_ready (cmd_ready),
        .out_free  (out_free),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .row_sel   (row_sel)
    );

    // Datapath: grid memory rewritten in place. New rows always come from
    // the old generation, since the window registers hold the old copies of
    // the rows above and below, and old row 0 is kept for the bottom wrap.
    lifet_datapath #(
        .GRID_WIDTH  (GRID_WIDTH),
        .GRID_HEIGHT (GRID_HEIGHT),
        .ROW_W       (ROW_W)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .rd_addr   (rd_addr),
        .row_sel   (row_sel),
        .cmd       (cmd),
        .out_free  (out_free),
        .res       (res),
        .res_valid (res_valid),
        .res_ready (res_ready)
    );

endmodule
